>>> design/imurp_pkg.sv
// Shared types, constants and helper functions for the roll/pitch filter.
package imurp_pkg;

  localparam int ANGLE_LIMIT = 11796480;
  localparam int ACC_LIMIT   = 89;

  localparam logic [1:0] CFG_GYRO_GAIN = 2'd0;
  localparam logic [1:0] CFG_STEP_TIME = 2'd1;
  localparam logic [1:0] CFG_BLEND     = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ0, ST_SQ1, ST_SQ2, ST_ANG, ST_WAIT, ST_RATE, ST_RATE2,
    ST_INT, ST_BW, ST_BA, ST_BS, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    AU_IDLE, AU_SQRT, AU_CHECK, AU_CORDIC, AU_FIN, AU_DONE
  } au_state_t;

  typedef struct packed {
    logic               start;
    logic signed [16:0] num;
    logic [31:0]        sq;
  } au_req_t;

  typedef struct packed {
    logic              done;
    logic signed [7:0] deg;
  } au_rsp_t;

  // Arctangent of 2^-i in Q16 degrees.
  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949080;
      5'd1:  v = 22'd1740944;
      5'd2:  v = 22'd919867;
      5'd3:  v = 22'd466939;
      5'd4:  v = 22'd234375;
      5'd5:  v = 22'd117302;
      5'd6:  v = 22'd58665;
      5'd7:  v = 22'd29334;
      5'd8:  v = 22'd14667;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // Saturate a wide Q16 angle to +-180 degrees.
  function automatic logic signed [24:0] sat_angle(input logic signed [47:0] v);
    logic signed [24:0] r;
    if (v > 48'sd11796480) begin
      r = 25'sd11796480;
    end else if (v < -48'sd11796480) begin
      r = -25'sd11796480;
    end else begin
      r = v[24:0];
    end
    return r;
  endfunction

endpackage

>>> design/imu_roll_pitch_complementary_filter_core.sv
// Top level of the roll/pitch complementary filter with its sequencer and shared multiplier.
//
// One raw IMU sample enters per transfer on the in_ channel; one result with the
// filtered roll and pitch angles (signed Q8.16 degrees) leaves per transfer on the
// out_ channel. Each axis first gets its accelerometer tilt angle: the two squares
// come from the shared multiplier, followed by a bit-serial square root and a
// vectoring CORDIC of CORDIC_ITERATIONS iterations. Then the gyro rate, the
// integration and the two blend products pass through the same 18 x 26 multiplier.
// An axis whose numerator or root is zero skips the CORDIC. The block takes a new
// sample only when it is idle; a finished result waits in the output register while
// the receiver stalls, and the block then waits with it before releasing the next
// sample.
// The cfg_ channel writes gyro_gain (0), step_time (1) and blend_weight (2); it is
// always ready and should be used only while the block is idle. Other indexes are
// ignored. Reset clears both angles to zero and loads the default register values.
module imu_roll_pitch_complementary_filter_core #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // roll_out, pitch_out, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import imurp_pkg::*;

  state_t             st_r, st_nxt;
  logic               axis_r;
  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r;
  logic [15:0]        gain_r, step_r;
  logic [16:0]        blend_r;
  logic signed [24:0] roll_r, pitch_r, angle_tmp_r;
  logic signed [7:0]  acc_r;
  logic [31:0]        sq_r;
  logic signed [47:0] sum_r;
  logic signed [43:0] prod_r;
  logic               out_valid_r;
  logic signed [24:0] out_roll_r, out_pitch_r;

  logic signed [17:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [15:0] b_sel, g_sel;
  logic signed [24:0] cur_angle;
  logic [16:0]        w_sat, w_comp;
  logic signed [16:0] rate_c;
  logic signed [47:0] int_sum, blend_sum;
  au_req_t            au_req;
  au_rsp_t            au_rsp;

  assign in_tready  = (st_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_pitch_r, out_roll_r};

  // The root's second term is ax for roll and ay for pitch.
  assign b_sel     = axis_r ? ay_r : ax_r;
  assign g_sel     = axis_r ? gy_r : gx_r;
  assign cur_angle = axis_r ? pitch_r : roll_r;
  assign w_sat     = (blend_r > 17'd65536) ? 17'd65536 : blend_r;
  assign w_comp    = 17'd65536 - w_sat;
  // Gyro rate, truncated toward zero to whole degrees per second.
  assign rate_c    = prod_r[32:16] + {16'd0, (prod_r[43] && (|prod_r[15:0]))};
  assign int_sum   = 48'(cur_angle) + 48'(prod_r);
  // The blend rounds toward minus infinity, which the arithmetic shift gives.
  assign blend_sum = sum_r + (48'(prod_r) <<< 16);

  assign au_req.start = (st_r == ST_ANG);
  assign au_req.num   = axis_r ? -17'(ax_r) : 17'(ay_r);
  assign au_req.sq    = sq_r;

  imurp_angle_unit #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_angle (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (au_req),
    .rsp  (au_rsp)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = 18'sd0;
    mul_b = 26'sd0;
    unique case (st_r)
      ST_SQ0: begin
        mul_a = 18'(az_r);
        mul_b = 26'(az_r);
      end
      ST_SQ1: begin
        mul_a = 18'(b_sel);
        mul_b = 26'(b_sel);
      end
      ST_RATE: begin
        mul_a = {2'b00, gain_r};
        mul_b = 26'(g_sel);
      end
      ST_RATE2: begin
        mul_a = {2'b00, step_r};
        mul_b = 26'(rate_c);
      end
      ST_BW: begin
        mul_a = {1'b0, w_sat};
        mul_b = 26'(angle_tmp_r);
      end
      ST_BA: begin
        mul_a = {1'b0, w_comp};
        mul_b = 26'(acc_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_tvalid) st_nxt = ST_SQ0;
      ST_SQ0:   st_nxt = ST_SQ1;
      ST_SQ1:   st_nxt = ST_SQ2;
      ST_SQ2:   st_nxt = ST_ANG;
      ST_ANG:   st_nxt = ST_WAIT;
      ST_WAIT:  if (au_rsp.done) st_nxt = ST_RATE;
      ST_RATE:  st_nxt = ST_RATE2;
      ST_RATE2: st_nxt = ST_INT;
      ST_INT:   st_nxt = ST_BW;
      ST_BW:    st_nxt = ST_BA;
      ST_BA:    st_nxt = ST_BS;
      ST_BS:    st_nxt = axis_r ? ST_DONE : ST_SQ0;
      ST_DONE:  if (!out_valid_r || out_tready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      roll_r      <= 25'sd0;
      pitch_r     <= 25'sd0;
      gain_r      <= 16'd500;
      step_r      <= 16'd197;
      blend_r     <= 17'd64225;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GYRO_GAIN: gain_r  <= cfg_data[15:0];
          CFG_STEP_TIME: step_r  <= cfg_data[15:0];
          CFG_BLEND:     blend_r <= cfg_data;
          default: begin
          end
        endcase
      end
      // In the done state the new result takes the register in the same cycle.
      if (out_valid_r && out_tready && (st_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          axis_r <= 1'b0;
          ax_r   <= in_tdata[15:0];
          ay_r   <= in_tdata[31:16];
          az_r   <= in_tdata[47:32];
          gx_r   <= in_tdata[63:48];
          gy_r   <= in_tdata[79:64];
        end
        ST_SQ1:  sq_r <= prod_r[31:0];
        ST_SQ2:  sq_r <= sq_r + prod_r[31:0];
        ST_WAIT: if (au_rsp.done) acc_r <= au_rsp.deg;
        ST_INT:  angle_tmp_r <= sat_angle(int_sum);
        ST_BA:   sum_r <= 48'(prod_r);
        ST_BS: begin
          if (axis_r) begin
            pitch_r <= sat_angle(blend_sum >>> 16);
          end else begin
            roll_r <= sat_angle(blend_sum >>> 16);
          end
          axis_r <= ~axis_r;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_roll_r  <= roll_r;
            out_pitch_r <= pitch_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The stored angles never leave the +-180 degree range.
  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    (roll_r <= 25'sd11796480) && (roll_r >= -25'sd11796480))
    else $error("roll angle out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_r <= 25'sd11796480) && (pitch_r >= -25'sd11796480))
    else $error("pitch angle out of range");

  // The tilt angle from the angle unit is clamped to +-89 degrees.
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RATE) |-> ((acc_r <= 8'sd89) && (acc_r >= -8'sd89)))
    else $error("accel angle out of range");

  // A sample transfer starts the sequence and closes the input.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still ready after a transfer");

endmodule

>>> design/imurp_angle_unit.sv
// Accelerometer tilt angle: bit-serial square root followed by a vectoring CORDIC.
module imurp_angle_unit #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  imurp_pkg::au_req_t req,
  output imurp_pkg::au_rsp_t rsp
);
  import imurp_pkg::*;

  localparam logic [4:0] ITER_LAST = 5'(CORDIC_ITERATIONS - 1);
  localparam logic [4:0] SQRT_LAST = 5'd23;

  au_state_t          st_r, st_nxt;
  logic [4:0]         cnt_r;
  logic [47:0]        rad_r;
  logic [26:0]        rem_r;
  logic [23:0]        root_r;
  logic signed [16:0] num_r;
  logic signed [35:0] x_r, y_r;
  logic signed [24:0] z_r;
  logic signed [7:0]  deg_r;

  logic [26:0]        rem_sh, trial;
  logic               ge;
  logic signed [35:0] xs, ys;
  logic signed [24:0] tab;
  logic signed [8:0]  zint;

  assign rem_sh = {rem_r[24:0], rad_r[47:46]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;
  assign tab    = {3'b000, atan_entry(cnt_r)};
  // Truncate the Q16 angle toward zero.
  assign zint   = z_r[24:16] + {8'd0, (z_r[24] && (|z_r[15:0]))};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      AU_IDLE:   if (req.start) st_nxt = AU_SQRT;
      AU_SQRT:   if (cnt_r == SQRT_LAST) st_nxt = AU_CHECK;
      AU_CHECK:  st_nxt = ((num_r == 17'sd0) || (root_r == 24'd0)) ? AU_DONE : AU_CORDIC;
      AU_CORDIC: if (cnt_r == ITER_LAST) st_nxt = AU_FIN;
      AU_FIN:    st_nxt = AU_DONE;
      AU_DONE:   st_nxt = AU_IDLE;
      default:   st_nxt = AU_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (st_r == AU_DONE);
    rsp.deg  = deg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= AU_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    case (st_r)
      AU_IDLE: begin
        cnt_r  <= 5'd0;
        rad_r  <= {req.sq, 16'd0};
        rem_r  <= 27'd0;
        root_r <= 24'd0;
        num_r  <= req.num;
      end
      AU_SQRT: begin
        rad_r  <= {rad_r[45:0], 2'b00};
        rem_r  <= ge ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[22:0], ge};
        cnt_r  <= cnt_r + 5'd1;
      end
      AU_CHECK: begin
        cnt_r <= 5'd0;
        x_r   <= {4'd0, root_r, 8'd0};
        y_r   <= {{3{num_r[16]}}, num_r, 16'd0};
        z_r   <= 25'sd0;
        if (num_r == 17'sd0) begin
          deg_r <= 8'sd0;
        end else begin
          deg_r <= num_r[16] ? -8'sd89 : 8'sd89;
        end
      end
      AU_CORDIC: begin
        if (!y_r[35]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + tab;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - tab;
        end
        cnt_r <= cnt_r + 5'd1;
      end
      AU_FIN: begin
        if (zint > 9'sd89) begin
          deg_r <= 8'sd89;
        end else if (zint < -9'sd89) begin
          deg_r <= -8'sd89;
        end else begin
          deg_r <= zint[7:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
